// ===== rtl/tsme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_pkg
// Shared constants, types and the Hann weight table of the soft mask estimator.
// ----------------------------------------------------------------------------
package tsme_pkg;

	localparam int unsigned HISTORY  = 8;
	localparam int unsigned MAX_BINS = 1024;
	localparam int unsigned SLOT_W   = $clog2(HISTORY);
	localparam int unsigned BIN_W    = $clog2(MAX_BINS);
	localparam int unsigned HIST_N   = HISTORY - 1;

	localparam int unsigned SAMP_W  = 24;
	localparam int unsigned RES_W   = 25;
	localparam int unsigned MASK_W  = 17;
	localparam int unsigned WGT_W   = 17;
	localparam int unsigned SQ_W    = 50;
	localparam int unsigned ACC_W   = 72;
	localparam int unsigned NORM_W  = 47;
	localparam int unsigned REM_W   = 49;
	localparam int unsigned QBITS   = 17;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int unsigned EPS_Q56 = 72;
	localparam longint unsigned TAYLOR_DEN [6] = '{6, 20, 42, 72, 110, 156};

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [BIN_W-1:0]  bin_t;

	typedef struct packed {
		logic signed [RES_W-1:0]  res_re;
		logic signed [RES_W-1:0]  res_im;
		logic signed [SAMP_W-1:0] msk_re;
		logic signed [SAMP_W-1:0] msk_im;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);
	localparam int unsigned ROW_W   = ENTRY_W * HISTORY;

	typedef entry_t [HISTORY-1:0] row_t;

	// one beat handed from the front end to the back end
	typedef struct packed {
		entry_t ent;
		bin_t   bin;
		slot_t  oldest;
		logic   primed;
		logic   last_bin;
	} item_t;

	typedef logic [WGT_W-1:0] hann_tab_t [HISTORY];

	function automatic logic [WGT_W-1:0] hann_weight(input int unsigned k);
		longint unsigned kr;
		longint unsigned x;
		longint unsigned t;
		longint s;
		longint unsigned sq;
		int i;
		kr = (2 * k > HIST_N) ? longint'(HIST_N - k) : longint'(k);
		x = (PI_Q30 * kr) / HIST_N;
		t = x;
		s = longint'(x);
		for (i = 1; i <= 6; i++) begin
			t = (t * x) >> 30;
			t = ((t * x) >> 30) / TAYLOR_DEN[i-1];
			if (i % 2 == 1) s = s - longint'(t);
			else s = s + longint'(t);
		end
		if (s < 0) s = 0;
		if (s > (longint'(1) << 30)) s = longint'(1) << 30;
		sq = (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
		return sq[WGT_W-1:0];
	endfunction

	function automatic hann_tab_t hann_table();
		hann_tab_t tab;
		int k;
		for (k = 0; k < HISTORY; k++) tab[k] = hann_weight(k);
		return tab;
	endfunction

	function automatic longint unsigned hann_sum();
		longint unsigned acc;
		int k;
		acc = 0;
		for (k = 0; k < HISTORY; k++) acc = acc + hann_weight(k);
		return acc;
	endfunction

	localparam hann_tab_t HANN_W = hann_table();
	localparam longint unsigned HANN_TOTAL = hann_sum();
	localparam logic [ACC_W-1:0] EPS_THR = ACC_W'((EPS_Q56 * HANN_TOTAL) >> 10);

	function automatic slot_t slot_add(input slot_t a, input slot_t b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SLOT_W+1)'(HISTORY)) s = s - (SLOT_W+1)'(HISTORY);
		return s[SLOT_W-1:0];
	endfunction

endpackage

// ===== rtl/temporal_soft_mask_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_soft_mask_estimator_top
// Wiener soft mask from Hann-weighted history of residual and masked power.
// ----------------------------------------------------------------------------
// One bin beat produces one result beat. With processing enabled each bin
// passes through the history row read-modify-write, the shared square/weight
// unit (seven steps per history slot), normalization and the bit-serial
// divider. With processing disabled a bin goes from the row update straight
// to the output. A two-beat queue lets the input keep accepting while the
// back end works, and a result register holds a result until it is taken.
// History memory is not cleared: the first frame after reset fills every
// slot of each bin row that it carries.
module temporal_soft_mask_estimator_top import tsme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] mix_re,
	input  logic signed [23:0] mix_im,
	input  logic signed [23:0] masked_re,
	input  logic signed [23:0] masked_im,
	input  logic               last_bin,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        mask_value,
	output logic               mask_valid,
	output logic signed [23:0] centered_mix_re,
	output logic signed [23:0] centered_mix_im,
	output logic signed [23:0] centered_masked_re,
	output logic signed [23:0] centered_masked_im,
	output logic               last_bin_out
);

	logic  enabled_q;
	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_not_empty;
	logic  pop;
	item_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) enabled_q <= 1'b1;
		else if (cfg_we) enabled_q <= cfg_wdata;
	end

	tsme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mix_re    (mix_re),
		.mix_im    (mix_im),
		.masked_re (masked_re),
		.masked_im (masked_im),
		.last_bin  (last_bin),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	tsme_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	tsme_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.enabled            (enabled_q),
		.q_not_empty        (q_not_empty),
		.q_head             (q_head),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.mask_value         (mask_value),
		.mask_valid         (mask_valid),
		.centered_mix_re    (centered_mix_re),
		.centered_mix_im    (centered_mix_im),
		.centered_masked_re (centered_masked_re),
		.centered_masked_im (centered_masked_im),
		.last_bin_out       (last_bin_out)
	);

endmodule

// ===== rtl/tsme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsme_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tsme_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tsme_fifo import tsme_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	item_t      slots_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wptr_q] <= push_item;
	end

endmodule

// ===== rtl/tsme_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_front
// Accepts bins, forms the residual and tracks bin index, slot and priming.
// ----------------------------------------------------------------------------
module tsme_front import tsme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] mix_re,
	input  logic signed [23:0] mix_im,
	input  logic signed [23:0] masked_re,
	input  logic signed [23:0] masked_im,
	input  logic               last_bin,
	input  logic               q_full,
	output logic               push,
	output item_t              push_item
);

	bin_t  bin_q;
	slot_t oldest_q;
	logic  primed_q;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.ent.res_re = RES_W'(mix_re) - RES_W'(masked_re);
		push_item.ent.res_im = RES_W'(mix_im) - RES_W'(masked_im);
		push_item.ent.msk_re = masked_re;
		push_item.ent.msk_im = masked_im;
		push_item.bin        = bin_q;
		push_item.oldest     = oldest_q;
		push_item.primed     = primed_q;
		push_item.last_bin   = last_bin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q    <= '0;
			oldest_q <= '0;
			primed_q <= 1'b0;
		end else if (push) begin
			if (last_bin) begin
				bin_q    <= '0;
				oldest_q <= slot_add(oldest_q, slot_t'(1));
				primed_q <= 1'b1;
			end else if (bin_q == BIN_W'(MAX_BINS - 1)) begin
				bin_q <= '0;
			end else begin
				bin_q <= bin_q + BIN_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tsme_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_back
// Updates the history row of a bin, accumulates weighted powers, divides.
// ----------------------------------------------------------------------------
module tsme_back import tsme_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enabled,
	input  logic               q_not_empty,
	input  item_t              q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        mask_value,
	output logic               mask_valid,
	output logic signed [23:0] centered_mix_re,
	output logic signed [23:0] centered_mix_im,
	output logic signed [23:0] centered_masked_re,
	output logic signed [23:0] centered_masked_im,
	output logic               last_bin_out
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_EPS  = 3'd3;
	localparam logic [2:0] S_NORM = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]                state_q;
	item_t                     item_q;
	row_t                      row_q;
	row_t                      rd_row;
	row_t                      new_row;
	logic [ROW_W-1:0]          rd_data;
	slot_t                     k_q;
	logic [2:0]                ph_q;
	logic [SQ_W-1:0]           sq_q;
	logic [SQ_W-1:0]           sm_q;
	logic [SQ_W-1:0]           sd_q;
	logic [ACC_W-1:0]          n_q;
	logic [ACC_W-1:0]          d_q;
	logic [REM_W-1:0]          rem_q;
	logic [QBITS-1:0]          quo_q;
	logic [4:0]                div_cnt_q;
	logic [MASK_W-1:0]         mask_q;
	entry_t                    ent;
	entry_t                    ctr;
	slot_t                     first_slot;
	slot_t                     centre_slot;
	logic [REM_W-1:0]          d_ext;
	logic                      ge;
	logic                      out_free;
	logic signed [RES_W-1:0]   sq_op;
	logic signed [2*RES_W-1:0] sq_prod;

	assign out_free    = !out_valid || out_ready;
	assign pop         = (state_q == S_IDLE) && q_not_empty;
	assign first_slot  = slot_add(item_q.oldest, slot_t'(1));
	assign centre_slot = slot_add(first_slot, slot_t'(HISTORY / 2));
	assign ent         = row_q[slot_add(first_slot, k_q)];
	assign ctr         = row_q[centre_slot];
	assign rd_row      = row_t'(rd_data);
	assign d_ext       = REM_W'(d_q[NORM_W-1:0]);
	assign ge          = rem_q >= d_ext;

	// one shared 25x25 squarer, operand picked by phase
	always_comb begin
		unique case (ph_q)
			3'd0:    sq_op = RES_W'(ent.msk_re);
			3'd1:    sq_op = RES_W'(ent.msk_im);
			3'd2:    sq_op = ent.res_re;
			default: sq_op = ent.res_im;
		endcase
	end

	assign sq_prod = sq_op * sq_op;

	always_comb begin
		for (int j = 0; j < HISTORY; j++) begin
			if (!item_q.primed || slot_t'(j) == item_q.oldest) new_row[j] = item_q.ent;
			else new_row[j] = rd_row[j];
		end
	end

	tsme_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BINS)) u_hist (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (item_q.bin),
		.wdata (ROW_W'(new_row)),
		.re    (pop),
		.raddr (q_head.bin),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_not_empty) state_q <= S_UPD;
				S_UPD:  state_q <= enabled ? S_ACC : S_OUT;
				S_ACC:  if (ph_q == 3'd6 && k_q == slot_t'(HISTORY - 1)) state_q <= S_EPS;
				S_EPS:  state_q <= (d_q > EPS_THR) ? S_NORM : S_OUT;
				S_NORM: if (d_q < (ACC_W'(1) << NORM_W)) state_q <= S_DIV;
				S_DIV:  if (div_cnt_q == 5'(QBITS - 1)) state_q <= S_OUT;
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (q_not_empty) item_q <= q_head;
			S_UPD: begin
				row_q  <= new_row;
				k_q    <= '0;
				ph_q   <= 3'd0;
				n_q    <= '0;
				d_q    <= '0;
				mask_q <= '0;
			end
			S_ACC: begin
				// four squares, two sums, then one weighted add each for N and D
				unique case (ph_q)
					3'd0: sq_q <= unsigned'(sq_prod);
					3'd1: begin
						sm_q <= sq_q;
						sq_q <= unsigned'(sq_prod);
					end
					3'd2: begin
						sm_q <= sm_q + sq_q;
						sq_q <= unsigned'(sq_prod);
					end
					3'd3: begin
						sd_q <= sm_q + sq_q;
						sq_q <= unsigned'(sq_prod);
					end
					3'd4: sd_q <= sd_q + sq_q;
					3'd5: n_q <= n_q + ACC_W'(sm_q * HANN_W[k_q]);
					default: d_q <= d_q + ACC_W'(sd_q * HANN_W[k_q]);
				endcase
				if (ph_q == 3'd6) begin
					ph_q <= 3'd0;
					k_q  <= k_q + slot_t'(1);
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
			S_EPS: ;
			S_NORM: begin
				if (d_q >= (ACC_W'(1) << NORM_W)) begin
					d_q <= d_q >> 1;
					n_q <= n_q >> 1;
				end else begin
					rem_q     <= REM_W'(n_q[NORM_W-1:0]);
					quo_q     <= '0;
					div_cnt_q <= '0;
				end
			end
			S_DIV: begin
				// restoring divide, one quotient bit per beat of the clock
				rem_q     <= ge ? (rem_q - d_ext) << 1 : rem_q << 1;
				quo_q     <= {quo_q[QBITS-2:0], ge};
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == 5'(QBITS - 1)) mask_q <= {quo_q[QBITS-2:0], ge};
			end
			S_OUT: begin
				if (out_free) begin
					mask_value         <= mask_q;
					mask_valid         <= enabled;
					centered_mix_re    <= SAMP_W'(ctr.res_re + RES_W'(ctr.msk_re));
					centered_mix_im    <= SAMP_W'(ctr.res_im + RES_W'(ctr.msk_im));
					centered_masked_re <= ctr.msk_re;
					centered_masked_im <= ctr.msk_im;
					last_bin_out       <= item_q.last_bin;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/tsme_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_checker
// Port-level checks on the result channel of the soft mask estimator.
// ----------------------------------------------------------------------------
module tsme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] mask_value,
	input logic        mask_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before accept");

	a_mask_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mask_value))
		else $error("mask changed while stalled");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mask_value <= 17'd65536)
		else $error("mask above one");

	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mask_valid |-> mask_value == 17'd0)
		else $error("mask nonzero while processing disabled");

endmodule

bind temporal_soft_mask_estimator_top tsme_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.mask_value (mask_value),
	.mask_valid (mask_valid)
);

// ===== dv/temporal_soft_mask_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_soft_mask_estimator_top_tb
// Streams spectral bins through the soft mask estimator and checks every
// result beat against an in-bench model of the per-bin history, Hann-weighted
// powers and Q1.16 mask. The first frame covers every bin row (and wraps past
// MAX_BINS), so no unwritten history entry is ever read. Both sides idle in
// random bursts, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module temporal_soft_mask_estimator_top_tb;
	import tsme_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned SETTLE      = 200;

	typedef struct {
		logic signed [23:0] mr, mi, kr, ki;
		logic               lb;
	} bin_beat_t;

	typedef struct {
		logic [16:0]        mask;
		logic               mvalid;
		logic signed [23:0] cmr, cmi, ckr, cki;
		logic               lb;
	} mask_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [23:0] mix_re = 0, mix_im = 0, masked_re = 0, masked_im = 0;
	logic last_bin = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [16:0] mask_value;
	logic mask_valid;
	logic signed [23:0] centered_mix_re, centered_mix_im;
	logic signed [23:0] centered_masked_re, centered_masked_im;
	logic last_bin_out;

	temporal_soft_mask_estimator_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.mix_re(mix_re), .mix_im(mix_im),
		.masked_re(masked_re), .masked_im(masked_im),
		.last_bin(last_bin),
		.out_valid(out_valid), .out_ready(out_ready),
		.mask_value(mask_value), .mask_valid(mask_valid),
		.centered_mix_re(centered_mix_re), .centered_mix_im(centered_mix_im),
		.centered_masked_re(centered_masked_re), .centered_masked_im(centered_masked_im),
		.last_bin_out(last_bin_out)
	);

	always #5 clk = ~clk;

	// model state
	logic signed [24:0] hist_res_re [MAX_BINS*HISTORY];
	logic signed [24:0] hist_res_im [MAX_BINS*HISTORY];
	logic signed [23:0] hist_msk_re [MAX_BINS*HISTORY];
	logic signed [23:0] hist_msk_im [MAX_BINS*HISTORY];
	int unsigned oldest_q, bin_q;
	bit primed_q;
	bit proc_en = 1;
	longint unsigned hann_tab [HISTORY];
	longint unsigned hann_tot;

	bin_beat_t bin_queue [$];
	mask_res_t mask_queue [$];
	bin_beat_t cur_bin;
	int unsigned err_cnt = 0;
	int unsigned in_gap = 0, out_gap = 0;
	bit quiet = 0;
	bit hold_req = 0, hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned cyc = 0;

	function automatic longint unsigned hann_coef(input int unsigned k);
		longint unsigned kr, x, t;
		longint s;
		int i;
		kr = (2 * k > HISTORY - 1) ? HISTORY - 1 - k : k;
		x = (PI_Q30 * kr) / (HISTORY - 1);
		t = x;
		s = longint'(x);
		for (i = 1; i <= 6; i++) begin
			t = (t * x) >> 30;
			t = ((t * x) >> 30) / longint'((2 * i) * (2 * i + 1));
			if (i % 2) s = s - longint'(t);
			else s = s + longint'(t);
		end
		if (s < 0) s = 0;
		if (s > (longint'(1) << 30)) s = longint'(1) << 30;
		return (longint'(s) * longint'(s) + (64'd1 << 43)) >> 44;
	endfunction

	function automatic longint unsigned power_of(input longint a, input longint b);
		return longint'(a * a + b * b);
	endfunction

	function automatic mask_res_t predict_bin(input bin_beat_t b);
		mask_res_t r;
		int unsigned row, first, p, c, k;
		logic signed [24:0] rre, rim;
		logic [127:0] num, den, sm, thr, q;
		row = (bin_q % MAX_BINS) * HISTORY;
		rre = {b.mr[23], b.mr} - {b.kr[23], b.kr};
		rim = {b.mi[23], b.mi} - {b.ki[23], b.ki};
		for (k = 0; k < HISTORY; k++) begin
			if (!primed_q || k == oldest_q) begin
				hist_res_re[row + k] = rre;
				hist_res_im[row + k] = rim;
				hist_msk_re[row + k] = b.kr;
				hist_msk_im[row + k] = b.ki;
			end
		end
		first = (oldest_q + 1) % HISTORY;
		q = 0;
		if (proc_en) begin
			num = 0;
			den = 0;
			for (k = 0; k < HISTORY; k++) begin
				p = row + (first + k) % HISTORY;
				sm = 128'(power_of(hist_msk_re[p], hist_msk_im[p]));
				num = num + sm * 128'(hann_tab[k]);
				den = den + (sm + 128'(power_of(hist_res_re[p], hist_res_im[p])))
					* 128'(hann_tab[k]);
			end
			thr = 128'((longint'(EPS_Q56) * hann_tot) >> 10);
			if (den > thr) begin
				while (den >= (128'd1 << 47)) begin
					den = den >> 1;
					num = num >> 1;
				end
				q = (num << 16) / den;
				if (q > 65536) q = 65536;
			end
		end
		c = row + (first + HISTORY / 2) % HISTORY;
		r.mask = q[16:0];
		r.mvalid = proc_en;
		r.cmr = 24'(int'(hist_res_re[c]) + int'(hist_msk_re[c]));
		r.cmi = 24'(int'(hist_res_im[c]) + int'(hist_msk_im[c]));
		r.ckr = hist_msk_re[c];
		r.cki = hist_msk_im[c];
		r.lb = b.lb;
		if (b.lb) begin
			bin_q = 0;
			oldest_q = (oldest_q + 1) % HISTORY;
			primed_q = 1;
		end else begin
			bin_q = (bin_q + 1) % MAX_BINS;
		end
		return r;
	endfunction

	task automatic report(input string fld, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", fld, got, want, $realtime);
		err_cnt++;
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) mask_queue = {mask_queue, predict_bin(cur_bin)};
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 0;
			end else if (bin_queue.size() > 0) begin
				cur_bin = bin_queue[0];
				bin_queue.delete(0);
				mix_re <= cur_bin.mr;
				mix_im <= cur_bin.mi;
				masked_re <= cur_bin.kr;
				masked_im <= cur_bin.ki;
				last_bin <= cur_bin.lb;
				in_valid <= 1;
				if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 6);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		mask_res_t w;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (mask_queue.size() == 0) begin
					$display("result beat with nothing expected at %0t", $realtime);
					err_cnt++;
				end else begin
					w = mask_queue[0];
					mask_queue.delete(0);
					if (mask_value !== w.mask) report("mask_value", mask_value, w.mask);
					if (mask_valid !== w.mvalid) report("mask_valid", mask_valid, w.mvalid);
					if (centered_mix_re !== w.cmr)
						report("centered_mix_re", centered_mix_re, w.cmr);
					if (centered_mix_im !== w.cmi)
						report("centered_mix_im", centered_mix_im, w.cmi);
					if (centered_masked_re !== w.ckr)
						report("centered_masked_re", centered_masked_re, w.ckr);
					if (centered_masked_im !== w.cki)
						report("centered_masked_im", centered_masked_im, w.cki);
					if (last_bin_out !== w.lb) report("last_bin_out", last_bin_out, w.lb);
				end
			end
			if (hold_left > 0) begin
				out_ready <= 0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 6);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'sh800000;
			1: return 24'sh7fffff;
			2: return 0;
			3: return $urandom_range(0, 1) ? 24'($urandom_range(0, 15))
				: -24'($urandom_range(0, 15));
			4: return 24'($urandom_range(0, 4095)) <<< $urandom_range(0, 11);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_bin(input logic signed [23:0] mr, mi, kr, ki, input logic lb);
		bin_beat_t b;
		b.mr = mr;
		b.mi = mi;
		b.kr = kr;
		b.ki = ki;
		b.lb = lb;
		bin_queue = {bin_queue, b};
	endtask

	// frames of random content; mostly short so history turns over quickly
	task automatic add_frames(input int unsigned n_items);
		int unsigned left, len, i;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			if (len > left) len = left;
			for (i = 0; i < len; i++)
				add_bin(pick_sample(), pick_sample(), pick_sample(), pick_sample(), i == len - 1);
			left -= len;
		end
	endtask

	task automatic drain();
		while (bin_queue.size() > 0 || in_valid || mask_queue.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(input logic v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		proc_en = v;
	endtask

	initial begin
		int unsigned k;
		oldest_q = 0;
		bin_q = 0;
		primed_q = 0;
		hann_tot = 0;
		for (k = 0; k < HISTORY; k++) begin
			hann_tab[k] = hann_coef(k);
			hann_tot += hann_tab[k];
		end
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// priming frame: disabled for speed, covers every row and wraps past MAX_BINS
		write_enable(0);
		add_bin(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 0);
		add_bin(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0);
		add_bin(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 0);
		add_bin(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff, 0);
		add_bin(0, 0, 0, 0, 0);
		add_bin(1, 0, 0, 1, 0);
		for (k = 6; k < MAX_BINS + 6; k++)
			add_bin(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
				k == MAX_BINS + 5);
		drain();

		// directed: zero power in bin 0 (epsilon), extremes, tiny values
		write_enable(1);
		for (k = 0; k < HISTORY; k++) add_bin(0, 0, 0, 0, 1);
		add_bin(24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff, 0);
		add_bin(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1);
		add_bin(0, 0, 1, 0, 0);
		add_bin(24'sh800000, 24'sh800000, 0, 0, 1);
		add_bin(0, 0, 24'sh800000, 24'sh800000, 1);
		add_frames(300);
		drain();

		// disabled: receiver stalls long while bins keep coming
		write_enable(0);
		add_frames(150);
		hold_req = 1;
		drain();

		write_enable(1);
		add_frames(200);
		while (bin_queue.size() > 80) @(posedge clk);
		quiet = 1;
		drain();
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
